// ----- rtl/core/dsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

  localparam int LEVEL_W   = 7;
  localparam int TIMER_W   = 9;
  localparam int BITCNT_W  = 4;
  localparam int ADDR_W    = 16;
  localparam int COUNT_W   = 12;
  localparam int BYTE_W    = 8;
  localparam int IN_USER_W = 4;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USED_W = LEVEL_W + ADDR_W + 1 + COUNT_W;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_REG    = 2'd1,
    CMD_ENABLE = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_LEVEL   = 2'd1,
    REG_ADDRESS = 2'd2,
    REG_LENGTH  = 2'd3
  } reg_sel_t;

  localparam logic [LEVEL_W-1:0]  LEVEL_UP_MAX   = 7'h7d;
  localparam logic [LEVEL_W-1:0]  LEVEL_DOWN_MIN = 7'h02;
  localparam logic [LEVEL_W-1:0]  LEVEL_STEP     = 7'h02;
  localparam logic [ADDR_W-1:0]   ADDR_WRAP_BASE = 16'h8000;
  localparam logic [1:0]          START_TOP_BITS = 2'b11;
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE  = 4'd8;

  // Control byte bit positions.
  localparam int CTRL_IRQ_EN = 7;
  localparam int CTRL_LOOP   = 6;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    reg_sel_t          reg_select;
    cmd_t              command;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bytes_left;
    logic               irq_pending;
    logic [ADDR_W-1:0]  fetch_address;
    logic               fetch_request;
    logic [LEVEL_W-1:0] level;
  } result_t;

  function automatic logic [TIMER_W-1:0] rate_period(input logic [3:0] idx);
    logic [TIMER_W-1:0] p;
    unique case (idx)
      4'h0: p = 9'h1ac;
      4'h1: p = 9'h17c;
      4'h2: p = 9'h154;
      4'h3: p = 9'h140;
      4'h4: p = 9'h11e;
      4'h5: p = 9'h0fe;
      4'h6: p = 9'h0e2;
      4'h7: p = 9'h0d6;
      4'h8: p = 9'h0be;
      4'h9: p = 9'h0a0;
      4'ha: p = 9'h08e;
      4'hb: p = 9'h080;
      4'hc: p = 9'h06a;
      4'hd: p = 9'h054;
      4'he: p = 9'h048;
      4'hf: p = 9'h036;
      default: p = 9'h1ac;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dsc_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsc_in_stage import dsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     load_ok,
  output logic          fire,
  output in_item_t      item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign fire     = valid_r && load_ok;
  assign in_ready = !valid_r || load_ok;
  assign item     = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dsc_channel_state.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsc_channel_state import dsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_item_t item,
  output result_t       result
);

  logic [BYTE_W-1:0]   ctrl_r, ctrl_nxt;
  logic [TIMER_W-1:0]  timer_r, timer_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [BYTE_W-1:0]   shift_r, shift_nxt;
  logic [BITCNT_W-1:0] bits_r, bits_nxt;
  logic [ADDR_W-1:0]   start_r, start_nxt;
  logic [ADDR_W-1:0]   cursor_r, cursor_nxt;
  logic [COUNT_W-1:0]  total_r, total_nxt;
  logic [COUNT_W-1:0]  remain_r, remain_nxt;
  logic                irq_r, irq_nxt;

  always_comb begin
    logic                do_clock;
    logic                byte_due;
    logic [COUNT_W-1:0]  remain_in;
    logic [COUNT_W-1:0]  remain_dec;
    logic                req;
    logic [ADDR_W-1:0]   req_addr;
    logic [LEVEL_W-1:0]  lvl_clk;
    logic [BYTE_W-1:0]   v;

    v          = item.data_byte;
    ctrl_nxt   = ctrl_r;
    timer_nxt  = timer_r;
    level_nxt  = level_r;
    shift_nxt  = shift_r;
    bits_nxt   = bits_r;
    start_nxt  = start_r;
    cursor_nxt = cursor_r;
    total_nxt  = total_r;
    remain_nxt = remain_r;
    irq_nxt    = irq_r;
    do_clock   = 1'b0;
    remain_in  = remain_r;

    unique case (item.command)
      CMD_TICK: begin
        if (timer_r == '0) begin
          timer_nxt = rate_period(ctrl_r[3:0]);
          do_clock  = 1'b1;
        end else begin
          timer_nxt = timer_r - 1'b1;
        end
      end
      CMD_REG: begin
        unique case (item.reg_select)
          REG_CONTROL: begin
            ctrl_nxt  = v;
            timer_nxt = rate_period(v[3:0]);
            if (!v[CTRL_IRQ_EN]) begin
              irq_nxt = 1'b0;
            end
          end
          REG_LEVEL: level_nxt = v[LEVEL_W-1:0];
          REG_ADDRESS: begin
            start_nxt  = {START_TOP_BITS, v, 6'b0};
            cursor_nxt = {START_TOP_BITS, v, 6'b0};
          end
          REG_LENGTH: begin
            total_nxt = {v, 4'b0001};
            if (remain_r == '0) begin
              remain_nxt = {v, 4'b0001};
            end
          end
          default: ;
        endcase
      end
      CMD_ENABLE: begin
        if (v[0]) begin
          if (remain_r == '0) begin
            remain_in  = total_r;
            remain_nxt = total_r;
          end
          do_clock = 1'b1;
        end else begin
          remain_nxt = '0;
        end
      end
      CMD_SAMPLE: shift_nxt = v;
      default: ;
    endcase

    // Output unit: step the level, then decide whether a new byte is due.
    lvl_clk = level_r;
    if (shift_r[0]) begin
      if (level_r <= LEVEL_UP_MAX) begin
        lvl_clk = level_r + LEVEL_STEP;
      end
    end else begin
      if (level_r >= LEVEL_DOWN_MIN) begin
        lvl_clk = level_r - LEVEL_STEP;
      end
    end

    byte_due = 1'b0;
    if (do_clock) begin
      if (bits_r != '0) begin
        level_nxt = lvl_clk;
        shift_nxt = shift_r >> 1;
        bits_nxt  = bits_r - 1'b1;
        byte_due  = (bits_r == 4'd1);
      end else begin
        byte_due = 1'b1;
      end
    end

    req        = 1'b0;
    req_addr   = '0;
    remain_dec = remain_in - 1'b1;
    if (byte_due && remain_in != '0) begin
      req        = 1'b1;
      req_addr   = cursor_r;
      bits_nxt   = BITS_PER_BYTE;
      cursor_nxt = (cursor_r + 1'b1) | ADDR_WRAP_BASE;
      remain_nxt = remain_dec;
      if (remain_dec == '0) begin
        if (ctrl_r[CTRL_LOOP]) begin
          remain_nxt = total_r;
          cursor_nxt = start_r;
        end else if (ctrl_r[CTRL_IRQ_EN]) begin
          irq_nxt = 1'b1;
        end
      end
    end

    result.level         = level_nxt;
    result.fetch_request = req;
    result.fetch_address = req_addr;
    result.irq_pending   = irq_nxt;
    result.bytes_left    = remain_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      timer_r  <= '0;
      level_r  <= '0;
      shift_r  <= '0;
      bits_r   <= '0;
      start_r  <= '0;
      cursor_r <= '0;
      total_r  <= '0;
      remain_r <= '0;
      irq_r    <= 1'b0;
    end else if (fire) begin
      ctrl_r   <= ctrl_nxt;
      timer_r  <= timer_nxt;
      level_r  <= level_nxt;
      shift_r  <= shift_nxt;
      bits_r   <= bits_nxt;
      start_r  <= start_nxt;
      cursor_r <= cursor_nxt;
      total_r  <= total_nxt;
      remain_r <= remain_nxt;
      irq_r    <= irq_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dsc_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dsc_out_stage import dsc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    fire,
  input  wire result_t result_in,
  output logic         load_ok,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      result
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  // A held beat may be replaced in the cycle it is taken.
  assign load_ok   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign result    = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/delta_sample_channel_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                    Beat content
// in_       in   tvalid/tready/tuser/tdata  one command: tick, register, enable, sample byte
// out_      out  tvalid/tready/tuser/tdata  channel status after that command
//
// Each input beat yields exactly one output beat. Throughput is one beat per
// cycle while out_tready stays high; out_tvalid rises after the accepting edge
// through the input register, then the channel update into the output register.
// rst_n is synchronous and clears all channel state and both valid flags.
// A stalled output holds its beat; the input register fills behind it and
// in_tready drops only when both stages are full.

module delta_sample_channel_core import dsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [1:0] command, [3:2] reg_select
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  // [7:0] data_byte
  input  wire logic [BYTE_W-1:0]     in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] fetch_request
  output logic [0:0]                 out_tuser,
  // [6:0] level, [22:7] fetch_address, [23] irq_pending, [35:24] bytes_left,
  // [39:36] zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  in_item_t in_item;
  in_item_t item;
  result_t  next_result;
  result_t  held_result;
  logic     fire;
  logic     load_ok;

  assign in_item.command    = cmd_t'(in_tuser[1:0]);
  assign in_item.reg_select = reg_sel_t'(in_tuser[3:2]);
  assign in_item.data_byte  = in_tdata;

  dsc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .load_ok  (load_ok),
    .fire     (fire),
    .item     (item)
  );

  dsc_channel_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (next_result)
  );

  dsc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .result_in (next_result),
    .load_ok   (load_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (held_result)
  );

  assign out_tuser = held_result.fetch_request;
  assign out_tdata = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                      held_result.bytes_left,
                      held_result.irq_pending,
                      held_result.fetch_address,
                      held_result.level};

endmodule

`default_nettype wire
